// ===== sv/adc_clock_divider_search_macros.svh =====
// ----------------------------------------------------------------------------
// ADC clock divider search assertion macros
// Shared assertion forms for the checker. Both sample on clk and are
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ADC_CLOCK_DIVIDER_SEARCH_MACROS_SVH
`define ADC_CLOCK_DIVIDER_SEARCH_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ACDS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("acds assertion failed");

// Same-cycle implication from an antecedent to a consequent.
`define ACDS_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("acds implication failed");

`endif

// ===== sv/acds_pkg.sv =====
// ----------------------------------------------------------------------------
// ADC clock divider search package
// Word types, widths, search constants and the divider saturation function.
// ----------------------------------------------------------------------------
package acds_pkg;

  localparam int CHANS_W = 5;
  localparam int RATE_W  = 18;
  localparam int CLOCK_W = 27;
  localparam int PROD_W  = CHANS_W + RATE_W;
  localparam int FACT_W  = 7;
  localparam int DEN_W   = 30;
  localparam int CMP_W   = DEN_W + 7;
  localparam int DIV_W   = 8;
  localparam int TIME_W  = 5;
  localparam int CNT_W   = 5;

  localparam logic [CLOCK_W-1:0] CLOCK_RESET   = 27'd40000000;
  localparam logic [TIME_W-1:0]  TIME_FIRST    = 5'd31;
  localparam logic [TIME_W-1:0]  TIME_LAST     = 5'd3;
  localparam logic [TIME_W-1:0]  TIME_NONE     = 5'd2;
  localparam logic [5:0]         TIME_OFFSET   = 6'd12;
  localparam logic [CMP_W-1:0]   PCT_SCALE     = 37'd100;
  localparam logic [CMP_W-1:0]   LOW_FRAC_PCT  = 37'd9;
  localparam logic [CMP_W-1:0]   HIGH_FRAC_PCT = 37'd91;
  localparam logic [DIV_W-1:0]   DIV_MAX       = 8'd255;
  localparam logic [CNT_W-1:0]   DIV_STEPS_M1  = 5'(CLOCK_W - 1);

  typedef struct packed {
    logic [CHANS_W-1:0] channel_count;
    logic [RATE_W-1:0]  rate_hz;
  } in_word_t;

  typedef struct packed {
    logic [DIV_W-1:0]  clock_divider;
    logic [TIME_W-1:0] sample_time;
    logic              fit_found;
  } out_word_t;

  typedef struct packed {
    logic start;
    logic mul_p;
    logic mul_d;
    logic div_step;
    logic check;
    logic load_out;
  } acds_cmd_t;

  typedef struct packed {
    logic prod_zero;
    logic div_done;
    logic fit_hit;
    logic t_last;
    logic out_free;
  } acds_sts_t;

  // Saturate a quotient, or the quotient less one, to the divider range.
  function automatic logic [DIV_W-1:0] clamp_div(input logic [CLOCK_W-1:0] q,
                                                 input logic minus_one);
    logic [CLOCK_W-1:0] v;
    logic [DIV_W-1:0]   res;
    v = minus_one ? q - 1'b1 : q;
    if (minus_one && (q == '0)) begin
      res = '0;
    end else if (v > CLOCK_W'(DIV_MAX)) begin
      res = DIV_MAX;
    end else begin
      res = v[DIV_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== sv/acds_ctrl.sv =====
// ----------------------------------------------------------------------------
// ADC clock divider search controller
// Sequences one word through the product, trial divisions and fit checks.
// ----------------------------------------------------------------------------
module acds_ctrl
  import acds_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output acds_cmd_t cmd,
  input  acds_sts_t sts
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MULP = 6'b000010,
    ST_MULD = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_CMP  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_MULP;
        end
      end
      ST_MULP: begin
        cmd.mul_p = 1'b1;
        state_nxt = ST_MULD;
      end
      ST_MULD: begin
        // A zero product makes every trial denominator zero: keep defaults.
        if (sts.prod_zero) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.mul_d = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.check = 1'b1;
        if (sts.fit_hit || sts.t_last) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_MULD;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/acds_datapath.sv =====
// ----------------------------------------------------------------------------
// ADC clock divider search datapath
// Clock register, trial denominator multiplier, restoring divider, fit
// compare and the output word register.
// ----------------------------------------------------------------------------
module acds_datapath
  import acds_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [CLOCK_W-1:0] cfg_wr_data,
  input  in_word_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_word_t          out_data,
  input  acds_cmd_t          cmd,
  output acds_sts_t          sts
);

  logic [CLOCK_W-1:0] clock_r;
  logic [CHANS_W-1:0] chans_r;
  logic [RATE_W-1:0]  rate_r;
  logic [PROD_W-1:0]  prod_r;
  logic [DEN_W-1:0]   den_r;
  logic [TIME_W-1:0]  t_r;
  logic [CLOCK_W-1:0] num_r;
  logic [DEN_W-1:0]   rem_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [DIV_W-1:0]   div_r;
  logic [TIME_W-1:0]  time_r;
  logic               fit_r;
  out_word_t          out_r;
  logic               out_valid_r;

  logic [5:0]         t_sum;
  logic [FACT_W-1:0]  factor;
  logic [DEN_W:0]     trial;
  logic               trial_ge;
  logic [CMP_W-1:0]   rem_scaled;
  logic               low_hit;
  logic               high_hit;

  assign t_sum  = {1'b0, t_r} + TIME_OFFSET;
  assign factor = {t_sum, 1'b0};

  // One restoring step: bring down the next clock bit, subtract if it fits.
  assign trial    = {rem_r, num_r[CLOCK_W-1]};
  assign trial_ge = (trial >= {1'b0, den_r});

  assign rem_scaled = CMP_W'(rem_r) * PCT_SCALE;
  assign low_hit    = (rem_scaled < (CMP_W'(den_r) * LOW_FRAC_PCT));
  assign high_hit   = (rem_scaled >= (CMP_W'(den_r) * HIGH_FRAC_PCT));

  assign sts.prod_zero = (prod_r == '0);
  assign sts.div_done  = (cnt_r == '0);
  assign sts.fit_hit   = low_hit || high_hit;
  assign sts.t_last    = (t_r == TIME_LAST);
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r <= CLOCK_RESET;
    end else if (cfg_wr_en) begin
      clock_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      chans_r <= in_data.channel_count;
      rate_r  <= in_data.rate_hz;
      t_r     <= TIME_FIRST;
      div_r   <= DIV_MAX;
      time_r  <= TIME_NONE;
      fit_r   <= 1'b0;
    end
    if (cmd.mul_p) begin
      prod_r <= PROD_W'(rate_r) * PROD_W'(chans_r);
    end
    if (cmd.mul_d) begin
      den_r <= DEN_W'(prod_r) * DEN_W'(factor);
      num_r <= clock_r;
      rem_r <= '0;
      cnt_r <= DIV_STEPS_M1;
    end
    if (cmd.div_step) begin
      rem_r <= trial_ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      num_r <= {num_r[CLOCK_W-2:0], trial_ge};
      cnt_r <= cnt_r - 1'b1;
    end
    if (cmd.check) begin
      // num_r now holds the quotient and rem_r the remainder.
      if (low_hit) begin
        div_r  <= clamp_div(num_r, 1'b1);
        time_r <= t_r;
        fit_r  <= 1'b1;
      end else if (high_hit) begin
        div_r  <= clamp_div(num_r, 1'b0);
        time_r <= t_r;
        fit_r  <= 1'b1;
      end else begin
        div_r <= clamp_div(num_r, 1'b1);
      end
      t_r <= t_r - 1'b1;
    end
    if (cmd.load_out) begin
      out_r.clock_divider <= div_r;
      out_r.sample_time   <= time_r;
      out_r.fit_found     <= fit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

// ===== sv/adc_clock_divider_search.sv =====
// ----------------------------------------------------------------------------
// ADC clock divider search
// Finds an acquisition time and conversion clock divider for a channel
// count and per-channel sample rate.
// ----------------------------------------------------------------------------
// Usage:
// A word on the in_ channel carries a channel count and a sample rate. While
// a word is being searched in_stall is high; the next word is taken once the
// result has moved into the output register, even if out_stall still holds
// the previous result there. The out_ word holds until the receiver lowers
// out_stall.
// The clock frequency is written through cfg_wr_en and cfg_wr_data; the user
// must do so only while the block is idle, which the block itself does not
// enforce. Reset loads 40 MHz and empties the output register.
// Each trial time runs one multiply, 27 restoring divider steps and one fit
// compare, on the one-bit-per-cycle divider. Up to 29 trial times are run per
// word, stopping at the first fit; a zero channel count or rate skips the
// trials. The block takes no new word until the last result is loaded out.
// ----------------------------------------------------------------------------
module adc_clock_divider_search
  import acds_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [CLOCK_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_word_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_word_t          out_data
);

  acds_cmd_t cmd;
  acds_sts_t sts;

  acds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  acds_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

// ===== sv/acds_checker.sv =====
// ----------------------------------------------------------------------------
// ADC clock divider search checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "adc_clock_divider_search_macros.svh"

module acds_checker
  import acds_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input out_word_t          out_data
);

  // A stalled result word stays put.
  `ACDS_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_data)))

  // Only one word is searched at a time.
  `ACDS_ASSERT(a_one_in_flight, (in_valid && !in_stall) |=> in_stall)

  // An exhausted search always reports the fallback time.
  `ACDS_IMPLY(a_no_fit_time, out_valid && !out_data.fit_found, out_data.sample_time == TIME_NONE)

  // A fit always names one of the searched times.
  `ACDS_IMPLY(a_fit_time, out_valid && out_data.fit_found,
              (out_data.sample_time >= TIME_LAST) && (out_data.sample_time <= TIME_FIRST))

endmodule

bind adc_clock_divider_search acds_checker u_acds_checker (.*);

// ===== sim/tb_adc_clock_divider_search.sv =====
// ----------------------------------------------------------------------------
// ADC clock divider search testbench
// Sends channel count and sample rate words under several source clock
// settings and checks each divider word against a local search routine or a
// hand-worked result. Both channels idle at random, and the receiver holds
// off for one long stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_adc_clock_divider_search;
  import acds_pkg::*;

  localparam int                 PROBE_COUNT   = 21;
  localparam int                 RANDOM_PHASES = 6;
  localparam int                 PHASE_WORDS   = 95;
  localparam int                 HOLD_CYCLES   = 4000;
  localparam int                 HOLD_AFTER    = 350;
  localparam int                 TAIL_CYCLES   = 900;
  localparam int                 CYCLE_LIMIT   = 3000000;
  localparam logic [CLOCK_W-1:0] CLOCK_TOP     = '1;
  // Ten times twice the rate: every trial lands in the dead band.
  localparam logic [CLOCK_W-1:0] CLOCK_NO_FIT  = 27'd20;

  typedef struct packed {
    logic [CLOCK_W-1:0] hz;
    in_word_t           word;
    logic               typed;
    out_word_t          want;
  } probe_row_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [CLOCK_W-1:0] cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  in_word_t           in_data;
  logic               out_valid;
  logic               out_stall;
  out_word_t          out_data;

  logic [CLOCK_W-1:0] clock_setting;
  logic               row_has_want;
  out_word_t          row_want;
  out_word_t          pending_settings[$];
  int unsigned        mismatch_count;
  int unsigned        settings_taken;
  int unsigned        cycle_count;
  logic               quiet;

  // Rows with a typed result are the ones that can be worked out by hand.
  probe_row_t probe_rows [PROBE_COUNT] = '{
    '{CLOCK_RESET,   '{5'd0,  18'd1000},   1'b1, '{DIV_MAX, TIME_NONE, 1'b0}},
    '{CLOCK_RESET,   '{5'd1,  18'd0},      1'b1, '{DIV_MAX, TIME_NONE, 1'b0}},
    '{CLOCK_RESET,   '{5'd0,  18'd0},      1'b1, '{DIV_MAX, TIME_NONE, 1'b0}},
    '{CLOCK_RESET,   '{5'd31, 18'd262143}, 1'b1, '{8'd0, TIME_FIRST, 1'b1}},
    '{CLOCK_RESET,   '{5'd16, 18'd200000}, 1'b0, '0},
    '{CLOCK_RESET,   '{5'd1,  18'd1},      1'b0, '0},
    '{CLOCK_RESET,   '{5'd16, 18'd1},      1'b0, '0},
    '{CLOCK_RESET,   '{5'd1,  18'd200000}, 1'b0, '0},
    '{CLOCK_RESET,   '{5'd4,  18'd1000},   1'b0, '0},
    '{CLOCK_RESET,   '{5'd8,  18'd44100},  1'b0, '0},
    '{CLOCK_RESET,   '{5'd31, 18'd1},      1'b0, '0},
    '{CLOCK_RESET,   '{5'd1,  18'd262143}, 1'b0, '0},
    '{27'd0,         '{5'd1,  18'd1},      1'b1, '{8'd0, TIME_FIRST, 1'b1}},
    '{27'd0,         '{5'd16, 18'd200000}, 1'b1, '{8'd0, TIME_FIRST, 1'b1}},
    '{27'd0,         '{5'd0,  18'd5},      1'b1, '{DIV_MAX, TIME_NONE, 1'b0}},
    '{CLOCK_NO_FIT,  '{5'd1,  18'd1},      1'b1, '{8'd0, TIME_NONE, 1'b0}},
    '{CLOCK_TOP,     '{5'd1,  18'd1},      1'b0, '0},
    '{CLOCK_TOP,     '{5'd31, 18'd262143}, 1'b0, '0},
    '{27'd1,         '{5'd1,  18'd1},      1'b1, '{8'd0, TIME_FIRST, 1'b1}},
    '{27'd100000000, '{5'd16, 18'd200000}, 1'b0, '0},
    '{27'd100000000, '{5'd2,  18'd3000},   1'b0, '0}
  };

  adc_clock_divider_search uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  function automatic logic [DIV_W-1:0] saturate8(input logic [63:0] v);
    return (v > 64'(DIV_MAX)) ? DIV_MAX : v[DIV_W-1:0];
  endfunction

  // Walks the acquisition times from longest to shortest and keeps the first
  // one whose ideal divider sits within nine percent of an integer.
  function automatic out_word_t search_divider(input in_word_t w,
                                               input logic [CLOCK_W-1:0] hz);
    logic [63:0] den;
    logic [63:0] quo;
    logic [63:0] rem;
    int          trial;
    out_word_t   res;
    res.clock_divider = DIV_MAX;
    res.sample_time   = TIME_NONE;
    res.fit_found     = 1'b0;
    for (trial = TIME_FIRST; trial >= TIME_LAST; trial--) begin
      den = 64'(2 * (trial + TIME_OFFSET)) * 64'(w.rate_hz) * 64'(w.channel_count);
      if (den == 0) begin
        res.clock_divider = DIV_MAX;
        continue;
      end
      quo = 64'(hz) / den;
      rem = 64'(hz) % den;
      if (64'(PCT_SCALE) * rem < 64'(LOW_FRAC_PCT) * den) begin
        res.clock_divider = saturate8((quo == 0) ? 64'd0 : quo - 1);
        res.sample_time   = TIME_W'(trial);
        res.fit_found     = 1'b1;
        break;
      end
      if (64'(PCT_SCALE) * rem >= 64'(HIGH_FRAC_PCT) * den) begin
        res.clock_divider = saturate8(quo);
        res.sample_time   = TIME_W'(trial);
        res.fit_found     = 1'b1;
        break;
      end
      // The truncated divider of the last trial stands if nothing fits.
      res.clock_divider = saturate8((quo == 0) ? 64'd0 : quo - 1);
    end
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(12, 60);
  endfunction

  // Nearly half the words have a rate tuned so that clock/(2*rate*chans) is a
  // chosen small ratio, which steers the search through many trials.
  function automatic in_word_t draw_word();
    in_word_t    w;
    int unsigned r;
    logic [63:0] ratio;
    logic [63:0] rate;
    r = $urandom_range(0, 99);
    w.channel_count = CHANS_W'($urandom_range(1, 16));
    w.rate_hz       = RATE_W'($urandom_range(1, 200000));
    if (r < 10) begin
      w.channel_count = CHANS_W'($urandom);
      w.rate_hz       = RATE_W'($urandom);
    end else if (r < 15) begin
      if ($urandom_range(0, 1) == 0) begin
        w.channel_count = '0;
        w.rate_hz       = RATE_W'($urandom);
      end else begin
        w.channel_count = CHANS_W'($urandom);
        w.rate_hz       = '0;
      end
    end else if (r >= 55) begin
      ratio = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 2000);
      rate  = 64'(clock_setting) / (2 * ratio * 64'(w.channel_count));
      if (rate == 0) begin
        rate = 1;
      end else if (rate > 64'(262143)) begin
        rate = 262143;
      end
      w.rate_hz = rate[RATE_W-1:0];
    end
    return w;
  endfunction

  task automatic send_word(input in_word_t w, input logic typed, input out_word_t want);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data      <= w;
    row_has_want <= typed;
    row_want     <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // The source clock only changes once every result is back.
  task automatic load_clock(input logic [CLOCK_W-1:0] hz);
    in_valid <= 1'b0;
    while (pending_settings.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en     <= 1'b1;
    cfg_wr_data   <= hz;
    clock_setting = hz;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off once enough words are in.
  initial begin
    bit          held;
    int unsigned gap;
    held      = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && settings_taken >= HOLD_AFTER) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        gap = pick_gap();
        if (gap != 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(negedge clk);
        end
      end
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : score
    out_word_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        if (row_has_want) begin
          pending_settings.push_back(row_want);
        end else begin
          pending_settings.push_back(search_divider(in_data, clock_setting));
        end
      end
      if (out_valid && !out_stall) begin
        settings_taken++;
        if (pending_settings.size() == 0) begin
          $error("unexpected word: clock_divider %0d sample_time %0d fit_found %0d",
                 out_data.clock_divider, out_data.sample_time, out_data.fit_found);
          mismatch_count++;
        end else begin
          want = pending_settings.pop_front();
          if (out_data.clock_divider !== want.clock_divider) begin
            $error("clock_divider: expected %0d, got %0d",
                   want.clock_divider, out_data.clock_divider);
            mismatch_count++;
          end
          if (out_data.sample_time !== want.sample_time) begin
            $error("sample_time: expected %0d, got %0d",
                   want.sample_time, out_data.sample_time);
            mismatch_count++;
          end
          if (out_data.fit_found !== want.fit_found) begin
            $error("fit_found: expected %0d, got %0d",
                   want.fit_found, out_data.fit_found);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    logic [CLOCK_W-1:0] phase_clocks [RANDOM_PHASES];
    int                 p;
    int                 n;
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    in_data        = '0;
    row_has_want   = 1'b0;
    row_want       = '0;
    clock_setting  = CLOCK_RESET;
    mismatch_count = 0;
    settings_taken = 0;
    quiet          = 1'b0;
    phase_clocks[0] = 27'd100000000;
    phase_clocks[1] = CLOCK_TOP;
    phase_clocks[2] = CLOCK_W'($urandom_range(1, 5000));
    phase_clocks[3] = CLOCK_W'($urandom_range(1, 134217727));
    phase_clocks[4] = 27'd48000000;
    phase_clocks[5] = CLOCK_W'($urandom_range(1000000, 100000000));
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (p = 0; p < PROBE_COUNT; p++) begin
      if (probe_rows[p].hz != clock_setting) begin
        load_clock(probe_rows[p].hz);
      end
      send_word(probe_rows[p].word, probe_rows[p].typed, probe_rows[p].want);
    end

    for (p = 0; p < RANDOM_PHASES; p++) begin
      load_clock(phase_clocks[p]);
      quiet = (p == 2);
      for (n = 0; n < PHASE_WORDS; n++) begin
        send_word(draw_word(), 1'b0, '0);
      end
    end
    quiet = 1'b0;

    in_valid <= 1'b0;
    while (pending_settings.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/acds_pkg.sv
sv/acds_ctrl.sv
sv/acds_datapath.sv
sv/adc_clock_divider_search.sv
sv/acds_checker.sv
sim/tb_adc_clock_divider_search.sv
